[rtl/core/i2cm_pkg.sv]
package i2cm_pkg;

    // command codes carried on the input tuser
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // active_command value when no sequence runs
    localparam logic [2:0] CMD_IDLE = 3'd0;

    // last phase index of each sequence
    localparam logic [4:0] LAST_START = 5'd2;
    localparam logic [4:0] LAST_STOP  = 5'd1;
    localparam logic [4:0] LAST_WRITE = 5'd25;
    localparam logic [4:0] LAST_READ  = 5'd19;

    // read byte: data bits in phases 0..15, ack bit 16..18
    localparam logic [4:0] RD_ACK_PHASE   = 5'd16;
    localparam logic [4:0] RD_ACK_SCL_LOW = 5'd17;
    localparam logic [4:0] RD_ACK_TAIL    = 5'd18;
    // write byte: data bits in phases 0..23, ack sample in 24
    localparam logic [4:0] WR_ACK_PHASE   = 5'd24;

    localparam int unsigned BYTE_W = 8;

    // phase within a written bit (phase index mod 3)
    localparam logic [1:0] WR_SUB [32] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
    };
    localparam logic [1:0] SUB_DRIVE = 2'd0;
    localparam logic [1:0] SUB_SCL   = 2'd1;
    localparam logic [1:0] SUB_TAIL  = 2'd2;

    // APB register map (word index = paddr[2])
    localparam logic REG_DELAY_TICKS = 1'b0;

    typedef struct packed {
        logic [2:0]        func;
        logic [BYTE_W-1:0] write_byte;
        logic              ack_after_read;
        logic              sda_in;
    } i2cm_item_t;

    typedef struct packed {
        logic              rejected;
        logic              ack_bit;
        logic [BYTE_W-1:0] read_data;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive_low;
        logic              scl_drive_low;
    } i2cm_res_t;

endpackage

[rtl/core/i2cm_in_stage.sv]
module i2cm_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cm_pkg::i2cm_item_t in_item,
    output logic                item_valid,
    input  logic                item_take,
    output i2cm_pkg::i2cm_item_t item
);
    import i2cm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    i2cm_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/i2cm_engine.sv]
module i2cm_engine #(
    parameter int unsigned DELAY_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [DELAY_WIDTH-1:0] delay_ticks,
    input  logic                   item_valid,
    output logic                   item_take,
    input  i2cm_pkg::i2cm_item_t   item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output i2cm_pkg::i2cm_res_t    res
);
    import i2cm_pkg::*;

    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [4:0]             phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0] dcount_reg, dcount_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic                   ack_reg, ack_next;
    logic                   res_valid_reg, res_valid_next;
    i2cm_res_t              res_reg, res_next;

    logic [DELAY_WIDTH-1:0] reload;
    logic [DELAY_WIDTH-1:0] dcount_dec;
    logic [4:0]             last_phase;
    logic                   busy;
    logic                   adv;

    // drive levels set at the beginning of phase p; returns {scl, sda}
    function automatic logic [1:0] begin_drive(
        input logic [2:0]        cmd,
        input logic [4:0]        p,
        input logic [BYTE_W-1:0] sh,
        input logic              ack,
        input logic              scl_in,
        input logic              sda_in
    );
        logic scl_o;
        logic sda_o;
        logic bitv;
        scl_o = scl_in;
        sda_o = sda_in;
        bitv  = sh[BYTE_W-1];
        case (cmd)
            FUNC_START:
            begin
                if (p == 5'd0)
                begin
                    scl_o = 1'b0;
                    sda_o = 1'b0;
                end
                else if (p == 5'd1)
                    sda_o = 1'b1;
                else
                    scl_o = 1'b1;
            end
            FUNC_STOP:
            begin
                if (p == 5'd0)
                    scl_o = 1'b0;
                else
                    sda_o = 1'b0;
            end
            FUNC_WRITE:
            begin
                if (p < WR_ACK_PHASE)
                begin
                    case (WR_SUB[p])
                        SUB_DRIVE:
                        begin
                            sda_o = ~bitv;
                            scl_o = 1'b0;
                        end
                        SUB_SCL:
                            scl_o = 1'b1;
                        default:
                        begin
                            // a 1 bit pulls SDA low again once SCL is low
                            if (bitv)
                                sda_o = 1'b1;
                        end
                    endcase
                end
                else if (p == WR_ACK_PHASE)
                begin
                    sda_o = 1'b0;
                    scl_o = 1'b0;
                end
                else
                    scl_o = 1'b1;
            end
            default:
            begin
                if (p < RD_ACK_PHASE)
                begin
                    if (!p[0])
                    begin
                        sda_o = 1'b0;
                        scl_o = 1'b0;
                    end
                    else
                        scl_o = 1'b1;
                end
                else if (p == RD_ACK_PHASE)
                begin
                    sda_o = ack;
                    scl_o = 1'b0;
                end
                else if (p == RD_ACK_SCL_LOW)
                    scl_o = 1'b1;
                else if (p == RD_ACK_TAIL)
                begin
                    if (!ack)
                        sda_o = 1'b1;
                end
            end
        endcase
        return {scl_o, sda_o};
    endfunction

    assign busy       = (cmd_reg != CMD_IDLE);
    assign reload     = (delay_ticks == '0) ? DELAY_WIDTH'(1) : delay_ticks;
    assign dcount_dec = (dcount_reg != '0) ? dcount_reg - DELAY_WIDTH'(1) : dcount_reg;
    assign adv        = item_valid && (!res_valid_reg || res_ready);
    assign item_take  = adv;

    always_comb
    begin
        case (cmd_reg)
            FUNC_START: last_phase = LAST_START;
            FUNC_STOP:  last_phase = LAST_STOP;
            FUNC_WRITE: last_phase = LAST_WRITE;
            default:    last_phase = LAST_READ;
        endcase
    end

    always_comb
    begin
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        cmd_next    = cmd_reg;
        phase_next  = phase_reg;
        dcount_next = dcount_reg;
        shift_next  = shift_reg;
        ack_next    = ack_reg;
        res_next    = '0;

        if (item.func inside {[FUNC_START:FUNC_READ]})
        begin
            if (busy)
                res_next.rejected = 1'b1;
            else
            begin
                cmd_next   = item.func;
                phase_next = 5'd0;
                if (item.func == FUNC_WRITE)
                    shift_next = item.write_byte;
                else if (item.func == FUNC_READ)
                begin
                    shift_next = '0;
                    ack_next   = item.ack_after_read;
                end
                {scl_next, sda_next} = begin_drive(item.func, 5'd0, shift_next, ack_next,
                                                   scl_reg, sda_reg);
                dcount_next = reload;
            end
        end
        else if (item.func == FUNC_TICK && busy)
        begin
            dcount_next = dcount_dec;
            if (dcount_dec == '0)
            begin
                // end-of-phase sampling and shifting
                if (cmd_reg == FUNC_WRITE)
                begin
                    if (phase_reg < WR_ACK_PHASE && WR_SUB[phase_reg] == SUB_TAIL)
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                    else if (phase_reg == WR_ACK_PHASE)
                        ack_next = item.sda_in;
                end
                else if (cmd_reg == FUNC_READ)
                begin
                    if (phase_reg < RD_ACK_PHASE && !phase_reg[0])
                        shift_next = {shift_reg[BYTE_W-2:0], item.sda_in};
                end

                if (phase_reg >= last_phase)
                begin
                    res_next.done_res = 1'b1;
                    if (cmd_reg == FUNC_READ)
                        res_next.read_data = shift_next;
                    if (cmd_reg == FUNC_WRITE)
                        res_next.ack_bit = ack_next;
                    cmd_next   = CMD_IDLE;
                    phase_next = 5'd0;
                end
                else
                begin
                    phase_next = phase_reg + 5'd1;
                    {scl_next, sda_next} = begin_drive(cmd_reg, phase_next, shift_next,
                                                       ack_next, scl_reg, sda_reg);
                    dcount_next = reload;
                end
            end
        end

        res_next.scl_drive_low = scl_next;
        res_next.sda_drive_low = sda_next;
        res_next.busy_res      = (cmd_next != CMD_IDLE);
    end

    assign res_valid_next = adv || (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b0;
            cmd_reg       <= CMD_IDLE;
            phase_reg     <= 5'd0;
            dcount_reg    <= '0;
            shift_reg     <= '0;
            ack_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (adv)
            begin
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                cmd_reg    <= cmd_next;
                phase_reg  <= phase_next;
                dcount_reg <= dcount_next;
                shift_reg  <= shift_next;
                ack_reg    <= ack_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg == CMD_IDLE) |-> (phase_reg == 5'd0))
        else $error("phase index nonzero while idle");

    a_busy_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (dcount_reg != '0))
        else $error("delay counter empty while a sequence runs");

    a_done_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.done_res && (res_reg.rejected || res_reg.busy_res)))
        else $error("done result flagged busy or rejected");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.done_res) |=> (cmd_reg == CMD_IDLE))
        else $error("sequence still active after done");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> $stable(cmd_reg) && $stable(phase_reg))
        else $error("state advanced while the result was stalled");
`endif

endmodule

[rtl/core/i2c_master_byte_sequencer_top.sv]
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  request: func, byte to send, ack choice, sampled SDA
// m_axis    out  m_tvalid/m_tready  drives, busy, done, read byte, ack bit, rejected
// apb       in   psel/penable       delay_ticks at byte address 0
//
// One request per clock sustained while m_tready stays high; a result passes through
// the input register, then the phase/drive update into the result register.
// Reset releases both lines, ends any sequence, sets delay_ticks to 100.
// A stalled m_axis holds the result; the input register takes one more request,
// then s_tready drops until the result is taken.
module i2c_master_byte_sequencer_top #(
    parameter int unsigned DELAY_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_byte[7:0], ack_after_read[8], sda_in[9], zero[15:10]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                   // done_res[3], read_data[11:4], ack_bit[12],
                                   // rejected[13], zero[15:14]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [DELAY_WIDTH-1:0] delay_next;
    logic                   cfg_write;
    i2cm_item_t             in_item;
    i2cm_item_t             item;
    logic                   item_valid;
    logic                   item_take;
    i2cm_res_t              res;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready && (paddr[2] == REG_DELAY_TICKS);
    assign delay_next = DELAY_WIDTH'(pwdata[15:0]);
    assign prdata     = (paddr[2] == REG_DELAY_TICKS) ? 32'(delay_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_WIDTH'(16'd100);
        else if (cfg_write)
            delay_reg <= delay_next;
    end

    assign in_item.func           = s_tuser;
    assign in_item.write_byte     = s_tdata[7:0];
    assign in_item.ack_after_read = s_tdata[8];
    assign in_item.sda_in         = s_tdata[9];

    i2cm_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    i2cm_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .delay_ticks (delay_reg),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item        (item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {2'b00, res.rejected, res.ack_bit, res.read_data, res.done_res,
                      res.busy_res, res.sda_drive_low, res.scl_drive_low};

endmodule

[bench/tb.sv]
module tb;
    import i2cm_pkg::*;

    localparam int unsigned LIMIT = 1000000;

    typedef enum int {PAT_LOW, PAT_HIGH, PAT_RANDOM} sda_pat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // write_byte[7:0], ack_after_read[8], sda_in[9], zero[15:10]
    logic [2:0]  s_tuser = '0;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                 // done_res[3], read_data[11:4], ack_bit[12],
                                 // rejected[13], zero[15:14]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_byte_sequencer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // engine state mirror
    logic [15:0] delay_reg = 16'd100;
    logic        scl_low = 1'b0;
    logic        sda_low = 1'b0;
    logic [2:0]  run_cmd = CMD_IDLE;
    logic [4:0]  run_phase = '0;
    logic [15:0] tick_left = '0;
    logic [7:0]  shift_reg = '0;
    logic        ack_reg = 1'b0;

    i2cm_item_t requests[$];
    i2cm_res_t  engine_states[$];
    i2cm_item_t cur_req;
    i2cm_res_t  got_state;
    i2cm_res_t  want_state;

    int          queued = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    int unsigned sink_draw;
    bit          no_idle = 1'b0;

    function automatic logic [15:0] reload_ticks();
        return (delay_reg == 16'd0) ? 16'd1 : delay_reg;
    endfunction

    function automatic logic [4:0] last_phase_of(logic [2:0] cmd);
        case (cmd)
            FUNC_START: return LAST_START;
            FUNC_STOP:  return LAST_STOP;
            FUNC_WRITE: return LAST_WRITE;
            default:    return LAST_READ;
        endcase
    endfunction

    function automatic void enter_phase(logic [4:0] p);
        logic bitv;
        bitv = shift_reg[7];
        case (run_cmd)
            FUNC_START: begin
                if (p == 5'd0) begin
                    scl_low = 1'b0;
                    sda_low = 1'b0;
                end else if (p == 5'd1) begin
                    sda_low = 1'b1;
                end else begin
                    scl_low = 1'b1;
                end
            end
            FUNC_STOP: begin
                if (p == 5'd0) scl_low = 1'b0;
                else sda_low = 1'b0;
            end
            FUNC_WRITE: begin
                if (p < WR_ACK_PHASE) begin
                    case (p % 3)
                        0: begin
                            sda_low = ~bitv;
                            scl_low = 1'b0;
                        end
                        1: scl_low = 1'b1;
                        default: if (bitv) sda_low = 1'b1;  // odd pull-down after a 1 bit
                    endcase
                end else if (p == WR_ACK_PHASE) begin
                    sda_low = 1'b0;
                    scl_low = 1'b0;
                end else begin
                    scl_low = 1'b1;
                end
            end
            default: begin
                if (p < RD_ACK_PHASE) begin
                    if (!p[0]) begin
                        sda_low = 1'b0;
                        scl_low = 1'b0;
                    end else begin
                        scl_low = 1'b1;
                    end
                end else if (p == RD_ACK_PHASE) begin
                    sda_low = ack_reg;
                    scl_low = 1'b0;
                end else if (p == RD_ACK_SCL_LOW) begin
                    scl_low = 1'b1;
                end else if (p == RD_ACK_TAIL) begin
                    if (!ack_reg) sda_low = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic void leave_phase(logic [4:0] p, logic sda);
        if (run_cmd == FUNC_WRITE) begin
            if (p < WR_ACK_PHASE && (p % 3) == 2) shift_reg = shift_reg << 1;
            else if (p == WR_ACK_PHASE) ack_reg = sda;
        end else if (run_cmd == FUNC_READ) begin
            if (p < RD_ACK_PHASE && !p[0]) shift_reg = {shift_reg[6:0], sda};
        end
    endfunction

    function automatic i2cm_res_t step_engine(i2cm_item_t it);
        i2cm_res_t r;
        r = '0;
        if (it.func >= FUNC_START && it.func <= FUNC_READ) begin
            if (run_cmd != CMD_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                run_cmd = it.func;
                run_phase = '0;
                if (it.func == FUNC_WRITE) begin
                    shift_reg = it.write_byte;
                end else if (it.func == FUNC_READ) begin
                    shift_reg = '0;
                    ack_reg = it.ack_after_read;
                end
                enter_phase(5'd0);
                tick_left = reload_ticks();
            end
        end else if (it.func == FUNC_TICK && run_cmd != CMD_IDLE) begin
            if (tick_left != 0) tick_left = tick_left - 16'd1;
            if (tick_left == 0) begin
                leave_phase(run_phase, it.sda_in);
                if (run_phase >= last_phase_of(run_cmd)) begin
                    r.done_res = 1'b1;
                    if (run_cmd == FUNC_READ) r.read_data = shift_reg;
                    if (run_cmd == FUNC_WRITE) r.ack_bit = ack_reg;
                    run_cmd = CMD_IDLE;
                    run_phase = '0;
                end else begin
                    run_phase = run_phase + 5'd1;
                    enter_phase(run_phase);
                    tick_left = reload_ticks();
                end
            end
        end
        r.scl_drive_low = scl_low;
        r.sda_drive_low = sda_low;
        r.busy_res = (run_cmd != CMD_IDLE);
        return r;
    endfunction

    task automatic log_mismatch(string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic cmp_field(string name, int got, int want);
        if (got != want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) engine_states.push_back(step_engine(cur_req));
            if (!s_tvalid || s_tready) begin
                if (src_wait != 0) begin
                    s_tvalid <= 1'b0;
                    src_wait <= src_wait - 1;
                end else if (requests.size() != 0) begin
                    cur_req = requests.pop_front();
                    s_tuser <= cur_req.func;
                    s_tdata <= {6'b0, cur_req.sda_in, cur_req.ack_after_read,
                                cur_req.write_byte};
                    s_tvalid <= 1'b1;
                    src_wait <= no_idle ? 0 : $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (engine_states.size() == 0) begin
                    log_mismatch("result with no request pending");
                end else begin
                    want_state = engine_states.pop_front();
                    got_state = m_tdata[13:0];
                    cmp_field("scl_drive_low", got_state.scl_drive_low, want_state.scl_drive_low);
                    cmp_field("sda_drive_low", got_state.sda_drive_low, want_state.sda_drive_low);
                    cmp_field("busy_res", got_state.busy_res, want_state.busy_res);
                    cmp_field("done_res", got_state.done_res, want_state.done_res);
                    cmp_field("read_data", got_state.read_data, want_state.read_data);
                    cmp_field("ack_bit", got_state.ack_bit, want_state.ack_bit);
                    cmp_field("rejected", got_state.rejected, want_state.rejected);
                end
                sink_draw = no_idle ? 0 : $urandom_range(0, 3);
                if (sink_draw != 0) begin
                    m_tready <= 1'b0;
                    sink_wait <= sink_draw;
                end
            end else if (!m_tready) begin
                if (sink_wait <= 1) m_tready <= 1'b1;
                else sink_wait <= sink_wait - 1;
            end
        end
    end

    function automatic logic pick_sda(sda_pat_t pat);
        case (pat)
            PAT_LOW:  return 1'b0;
            PAT_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    function automatic int ticks_for(logic [2:0] f);
        return (int'(last_phase_of(f)) + 1) * int'(reload_ticks());
    endfunction

    task automatic push_req(logic [2:0] f, logic [7:0] b, logic a, logic sda);
        i2cm_item_t r;
        r.func = f;
        r.write_byte = b;
        r.ack_after_read = a;
        r.sda_in = sda;
        requests.push_back(r);
        queued++;
    endtask

    task automatic push_ticks(int n, sda_pat_t pat);
        repeat (n) push_req(FUNC_TICK, 8'($urandom), 1'($urandom), pick_sda(pat));
    endtask

    // command plus exactly the ticks it needs; noise requests go in while busy
    task automatic push_run(logic [2:0] f, logic [7:0] b, logic a, sda_pat_t pat, int noise_pct);
        int n;
        n = ticks_for(f);
        push_req(f, b, a, pick_sda(pat));
        for (int i = 0; i < n; i++) begin
            push_req(FUNC_TICK, 8'($urandom), 1'($urandom), pick_sda(pat));
            if (i < n - 1 && $urandom_range(0, 99) < noise_pct)
                push_req(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (requests.size() != 0 || s_tvalid || engine_states.size() != 0) @(negedge clk);
    endtask

    task automatic apb_write(logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_DELAY_TICKS, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        delay_reg = val;
    endtask

    task automatic set_delay(logic [15:0] val);
        drain();
        repeat (4) @(posedge clk);
        apb_write(val);
    endtask

    task automatic random_phase(logic [15:0] dly, int target);
        int first;
        int pick;
        bit paused;
        logic [2:0] f;
        set_delay(dly);
        first = queued;
        paused = 1'b0;
        while (queued - first < target) begin
            // hold off once mid-phase until the pipe is empty
            if (!paused && queued - first > target / 2) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            f = 3'($urandom_range(FUNC_START, FUNC_READ));
            if (pick < 75) begin
                push_run(f, 8'($urandom), 1'($urandom), PAT_RANDOM, 8);
            end else if (pick < 90) begin
                push_req(f, 8'($urandom), 1'($urandom), 1'($urandom));
                push_ticks($urandom_range(0, ticks_for(f)), PAT_RANDOM);
            end else begin
                repeat ($urandom_range(1, 8))
                    push_req(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
        // longest sequence is a write; this always lets the engine finish
        push_ticks(ticks_for(FUNC_WRITE), PAT_RANDOM);
    endtask

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset delay: idle tick, unused codes, a stop with commands while busy
        push_req(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
        push_req(3'd5, 8'h00, 1'b0, 1'b0);
        push_req(3'd6, 8'hFF, 1'b1, 1'b1);
        push_req(3'd7, 8'h55, 1'b0, 1'b1);
        push_run(FUNC_STOP, 8'h00, 1'b0, PAT_RANDOM, 5);

        set_delay(16'd1);
        push_run(FUNC_START, 8'h00, 1'b0, PAT_RANDOM, 0);
        push_run(FUNC_WRITE, 8'h00, 1'b0, PAT_LOW, 0);
        push_run(FUNC_WRITE, 8'hFF, 1'b1, PAT_HIGH, 0);
        push_run(FUNC_WRITE, 8'hA5, 1'b0, PAT_RANDOM, 20);
        push_run(FUNC_READ, 8'h00, 1'b1, PAT_HIGH, 0);
        push_run(FUNC_READ, 8'hFF, 1'b0, PAT_LOW, 0);
        push_run(FUNC_READ, 8'h3C, 1'b1, PAT_RANDOM, 20);
        push_run(FUNC_STOP, 8'h00, 1'b0, PAT_RANDOM, 0);
        push_req(3'd7, 8'hFF, 1'b1, 1'b1);

        // zero delay register acts as one tick per phase
        random_phase(16'd0, 40);

        // longer delay: one stop sequence, a read rejected while it runs, no idling on either side
        set_delay(16'd45);
        no_idle = 1'b1;
        push_req(FUNC_STOP, 8'h00, 1'b0, 1'b0);
        push_req(FUNC_READ, 8'hFF, 1'b1, 1'b1);
        push_ticks(ticks_for(FUNC_STOP), PAT_RANDOM);
        drain();
        no_idle = 1'b0;

        random_phase(16'd1, 120);
        random_phase(16'd2, 100);
        random_phase(16'($urandom_range(1, 4)), 80);
        random_phase(16'd3, 80);
        no_idle = 1'b1;
        random_phase(16'd1, 50);
        drain();
        no_idle = 1'b0;

        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_in_stage.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_byte_sequencer_top.sv
bench/tb.sv
